// ===== sv/capwm_pkg.sv =====
// shared types and constants of the center-aligned pwm timer
package capwm_pkg;

    localparam int NUM_CH = 4;

    // item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_DUTY  = 2'd1;
    localparam logic [1:0] MODE_FORCE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MAX_COUNT  = 3'd0;
    localparam logic [2:0] REG_CNT_ENABLE = 3'd1;
    localparam logic [2:0] REG_CH_ENABLE  = 3'd2;
    localparam logic [2:0] REG_POL_INVERT = 3'd3;
    localparam logic [2:0] REG_IRQ_ENABLE = 3'd4;

    // register reset values
    localparam logic [15:0] RST_MAX_COUNT  = 16'd4200;
    localparam logic        RST_CNT_ENABLE = 1'b1;
    localparam logic [3:0]  RST_CH_ENABLE  = 4'hf;
    localparam logic [3:0]  RST_POL_INVERT = 4'h0;
    localparam logic        RST_IRQ_ENABLE = 1'b1;

    // 100 percent in q8.8
    localparam logic [14:0] FULL_RAW = 15'd25600;
    // x / 25600 = (x >> 10) / 25, the divide by 25 as multiply by ceil(2^26 / 25)
    // split into two 11-bit halves
    localparam logic [10:0] RECIP_HI = 11'd1310;
    localparam logic [10:0] RECIP_LO = 11'd1475;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] duty_one;
        logic signed [15:0] duty_two;
        logic signed [15:0] duty_three;
        logic signed [15:0] duty_four;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  pwm_level;
        logic [15:0] count_now;
        logic        counting_down;
        logic        update_event;
        logic        update_irq;
    } t_out_item;

endpackage

// ===== sv/capwm_duty_scale.sv =====
// duty scaler lane: clamp q8.8 percent and scale to a compare value over two stages
module capwm_duty_scale (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_duty,
    input  logic [15:0]        i_max_count,
    output logic [15:0]        o_compare
);

    logic [14:0] raw;
    logic [30:0] n_product;
    logic [30:0] r_product;
    logic [20:0] scaled;
    logic [31:0] n_part_hi;
    logic [31:0] n_part_lo;
    logic [31:0] r_part_hi;
    logic [31:0] r_part_lo;
    logic [42:0] sum;
    logic [16:0] quotient;

    always_comb begin
        if (i_duty[15]) begin
            raw = '0;
        end else if (i_duty[14:0] > capwm_pkg::FULL_RAW) begin
            raw = capwm_pkg::FULL_RAW;
        end else begin
            raw = i_duty[14:0];
        end
    end

    assign n_product = {15'b0, i_max_count} * {16'b0, raw};
    assign scaled    = r_product[30:10];
    assign n_part_hi = {11'b0, scaled} * {21'b0, capwm_pkg::RECIP_HI};
    assign n_part_lo = {11'b0, scaled} * {21'b0, capwm_pkg::RECIP_LO};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= n_product;
            r_part_hi <= n_part_hi;
            r_part_lo <= n_part_lo;
        end
    end

    assign sum       = {r_part_hi, 11'b0} + {11'b0, r_part_lo};
    assign quotient  = sum[42:26];
    assign o_compare = quotient[16] ? 16'hffff : quotient[15:0];

endmodule

// ===== sv/center_aligned_pwm_timer_top.sv =====
// top level of the four-channel center-aligned pwm timer
// Takes one item per clock while the output is not stalled and returns one result item for
// each; the result item passes stage one, stage two and the output register. i_out_ready
// stalling the output register holds the whole pipeline, and o_in_ready is high whenever
// that register is empty or being taken. The counter and direction update at acceptance;
// a duty item passes through the two-stage multiply of each scaler lane and writes its
// preload compare in the last stage, where update events also copy preloads to the active
// compares in item order, so a forced update right after a duty item already sees the new
// duties. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, as the block itself does not enforce this.
module center_aligned_pwm_timer_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  capwm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output capwm_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam int NCH = capwm_pkg::NUM_CH;

    logic [15:0] r_max_count;
    logic        r_cnt_en;
    logic [3:0]  r_ch_en;
    logic [3:0]  r_pol_inv;
    logic        r_irq_en;

    logic [15:0] r_counter;
    logic        r_dir;
    logic [15:0] n_counter;
    logic        n_dir;
    logic        n_event;

    logic [15:0] r_preload [NCH];
    logic [15:0] r_active  [NCH];
    logic [15:0] lane_cmp  [NCH];
    logic [15:0] duty_in   [NCH];
    logic [15:0] cmp_eff   [NCH];

    logic        adv;
    logic        in_fire;
    logic        r_v1;
    logic        r_v2;
    logic        r_vo;
    logic [15:0] r_s1_count;
    logic        r_s1_dir;
    logic        r_s1_event;
    logic        r_s1_duty;
    logic [15:0] r_s2_count;
    logic        r_s2_dir;
    logic        r_s2_event;
    logic        r_s2_duty;
    logic [3:0]  n_level;
    capwm_pkg::t_out_item r_out;

    logic [15:0] mc_eff;
    logic [15:0] reload;

    assign adv        = !r_vo || i_out_ready;
    assign o_in_ready = adv;
    assign in_fire    = i_in_valid && adv;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= capwm_pkg::RST_MAX_COUNT;
            r_cnt_en    <= capwm_pkg::RST_CNT_ENABLE;
            r_ch_en     <= capwm_pkg::RST_CH_ENABLE;
            r_pol_inv   <= capwm_pkg::RST_POL_INVERT;
            r_irq_en    <= capwm_pkg::RST_IRQ_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                capwm_pkg::REG_MAX_COUNT:  r_max_count <= i_cfg_data;
                capwm_pkg::REG_CNT_ENABLE: r_cnt_en    <= i_cfg_data[0];
                capwm_pkg::REG_CH_ENABLE:  r_ch_en     <= i_cfg_data[3:0];
                capwm_pkg::REG_POL_INVERT: r_pol_inv   <= i_cfg_data[3:0];
                capwm_pkg::REG_IRQ_ENABLE: r_irq_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // up/down counter; a period below two counts as two
    assign mc_eff = (r_max_count < 16'd2) ? 16'd2 : r_max_count;
    assign reload = mc_eff - 16'd1;

    always_comb begin
        n_counter = r_counter;
        n_dir     = r_dir;
        n_event   = 1'b0;
        case (i_in_item.mode)
            capwm_pkg::MODE_TICK: begin
                if (r_cnt_en) begin
                    if (!r_dir) begin
                        if ({1'b0, r_counter} + 17'd1 >= {1'b0, reload}) begin
                            n_counter = reload;
                            n_dir     = 1'b1;
                            n_event   = 1'b1;
                        end else begin
                            n_counter = r_counter + 16'd1;
                        end
                    end else if (r_counter <= 16'd1) begin
                        n_counter = '0;
                        n_dir     = 1'b0;
                        n_event   = 1'b1;
                    end else begin
                        n_counter = r_counter - 16'd1;
                    end
                end
            end
            capwm_pkg::MODE_FORCE: begin
                n_counter = '0;
                n_dir     = 1'b0;
                n_event   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_dir     <= 1'b0;
        end else if (in_fire) begin
            r_counter <= n_counter;
            r_dir     <= n_dir;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= in_fire;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_count <= n_counter;
            r_s1_dir   <= n_dir;
            r_s1_event <= n_event;
            r_s1_duty  <= (i_in_item.mode == capwm_pkg::MODE_DUTY);
            r_s2_count <= r_s1_count;
            r_s2_dir   <= r_s1_dir;
            r_s2_event <= r_s1_event;
            r_s2_duty  <= r_s1_duty;
        end
    end

    assign duty_in[0] = i_in_item.duty_one;
    assign duty_in[1] = i_in_item.duty_two;
    assign duty_in[2] = i_in_item.duty_three;
    assign duty_in[3] = i_in_item.duty_four;

    for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
        capwm_duty_scale u_scale (
            .i_clk       (i_clk),
            .i_en        (adv),
            .i_duty      (duty_in[ch]),
            .i_max_count (r_max_count),
            .o_compare   (lane_cmp[ch])
        );

        // last stage: duty items write preloads, update events copy them
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_preload[ch] <= '0;
                r_active[ch]  <= '0;
            end else if (adv && r_v2) begin
                if (r_s2_duty) begin
                    r_preload[ch] <= lane_cmp[ch];
                end
                if (r_s2_event) begin
                    r_active[ch] <= r_preload[ch];
                end
            end
        end

        assign cmp_eff[ch] = r_s2_event ? r_preload[ch] : r_active[ch];
        assign n_level[ch] = r_ch_en[ch] && ((r_s2_count < cmp_eff[ch]) ^ r_pol_inv[ch]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.pwm_level     <= n_level;
            r_out.count_now     <= r_s2_count;
            r_out.counting_down <= r_s2_dir;
            r_out.update_event  <= r_s2_event;
            r_out.update_irq    <= r_s2_event && r_irq_en;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_force_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_item.mode == capwm_pkg::MODE_FORCE |=> r_counter == 16'd0 && !r_dir)
        else $error("forced update did not restart the counter");

    a_down_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_item.mode == capwm_pkg::MODE_TICK && r_cnt_en && r_dir
        && r_counter > 16'd1 |=> r_counter == $past(r_counter) - 16'd1)
        else $error("falling counter did not decrement");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv && r_v2 |=> r_v2 && r_vo)
        else $error("pipeline item lost during stall");

    a_irq_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_out.update_irq |-> r_out.update_event && r_irq_en)
        else $error("interrupt without update event");
`endif

endmodule

// ===== tb/capwm_checker.sv =====
// checker of the pwm timer: tracks the counter and compares every result item
module capwm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  capwm_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  capwm_pkg::t_out_item i_out_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output int                   o_items_in,
    output int                   o_items_out,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // register copy
    logic [15:0] period_cfg;
    logic        run_en;
    logic [3:0]  ch_en;
    logic [3:0]  pol_inv;
    logic        irq_en;

    // timer state
    logic [15:0] count_val;
    logic        falling;
    logic [15:0] compare_pre [capwm_pkg::NUM_CH];
    logic [15:0] compare_act [capwm_pkg::NUM_CH];

    capwm_pkg::t_out_item pwm_result_q [$];
    int                   fail_cnt;

    assign o_fail_count = fail_cnt;

    // clamp the q8.8 percent to 0..100 and scale it to the period
    function automatic logic [15:0] percent_to_compare(input logic [15:0] pct);
        int          v;
        longint      prod;
        v = $signed(pct);
        if (v < 0) v = 0;
        if (v > int'(capwm_pkg::FULL_RAW)) v = int'(capwm_pkg::FULL_RAW);
        prod = longint'(period_cfg) * longint'(v) / longint'(capwm_pkg::FULL_RAW);
        if (prod > 65535) prod = 65535;
        return prod[15:0];
    endfunction

    // one count step up or down, returns 1 on overflow or underflow
    function automatic logic step_counter();
        logic [15:0] reload;
        reload = (period_cfg < 16'd2) ? 16'd1 : period_cfg - 16'd1;
        if (!falling) begin
            if ({16'd0, count_val} + 32'd1 >= {16'd0, reload}) begin
                count_val = reload;
                falling   = 1'b1;
                return 1'b1;
            end
            count_val = count_val + 16'd1;
            return 1'b0;
        end
        if (count_val <= 16'd1) begin
            count_val = 16'd0;
            falling   = 1'b0;
            return 1'b1;
        end
        count_val = count_val - 16'd1;
        return 1'b0;
    endfunction

    task automatic advance_timer(input capwm_pkg::t_in_item it);
        capwm_pkg::t_out_item res;
        logic      ev;
        logic      on;
        int        ch;
        ev = 1'b0;
        case (it.mode)
            capwm_pkg::MODE_TICK: begin
                if (run_en) ev = step_counter();
            end
            capwm_pkg::MODE_DUTY: begin
                compare_pre[0] = percent_to_compare(it.duty_one);
                compare_pre[1] = percent_to_compare(it.duty_two);
                compare_pre[2] = percent_to_compare(it.duty_three);
                compare_pre[3] = percent_to_compare(it.duty_four);
            end
            capwm_pkg::MODE_FORCE: begin
                count_val = 16'd0;
                falling   = 1'b0;
                ev        = 1'b1;
            end
            default: ;
        endcase
        if (ev) begin
            for (ch = 0; ch < capwm_pkg::NUM_CH; ch++) compare_act[ch] = compare_pre[ch];
        end
        for (ch = 0; ch < capwm_pkg::NUM_CH; ch++) begin
            on = count_val < compare_act[ch];
            if (pol_inv[ch]) on = !on;
            if (!ch_en[ch]) on = 1'b0;
            res.pwm_level[ch] = on;
        end
        res.count_now     = count_val;
        res.counting_down = falling;
        res.update_event  = ev;
        res.update_irq    = ev & irq_en;
        pwm_result_q.push_back(res);
    endtask

    task automatic check_result(input capwm_pkg::t_out_item got);
        capwm_pkg::t_out_item exp;
        if (pwm_result_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
                $display("result %0d arrived with nothing expected", o_items_out);
            return;
        end
        exp = pwm_result_q.pop_front();
        if (got.pwm_level !== exp.pwm_level || got.count_now !== exp.count_now ||
            got.counting_down !== exp.counting_down ||
            got.update_event !== exp.update_event || got.update_irq !== exp.update_irq) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
                $display({"result %0d: expected level %h count %0d down %b event %b irq %b,",
                          " got level %h count %0d down %b event %b irq %b"}, o_items_out,
                         exp.pwm_level, exp.count_now, exp.counting_down, exp.update_event,
                         exp.update_irq, got.pwm_level, got.count_now, got.counting_down,
                         got.update_event, got.update_irq);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_cfg  = capwm_pkg::RST_MAX_COUNT;
            run_en      = capwm_pkg::RST_CNT_ENABLE;
            ch_en       = capwm_pkg::RST_CH_ENABLE;
            pol_inv     = capwm_pkg::RST_POL_INVERT;
            irq_en      = capwm_pkg::RST_IRQ_ENABLE;
            count_val   = 16'd0;
            falling     = 1'b0;
            for (int ch = 0; ch < capwm_pkg::NUM_CH; ch++) begin
                compare_pre[ch] = 16'd0;
                compare_act[ch] = 16'd0;
            end
            pwm_result_q.delete();
            fail_cnt    = 0;
            o_items_in  <= 0;
            o_items_out <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    capwm_pkg::REG_MAX_COUNT:  period_cfg = i_cfg_data;
                    capwm_pkg::REG_CNT_ENABLE: run_en     = i_cfg_data[0];
                    capwm_pkg::REG_CH_ENABLE:  ch_en      = i_cfg_data[3:0];
                    capwm_pkg::REG_POL_INVERT: pol_inv    = i_cfg_data[3:0];
                    capwm_pkg::REG_IRQ_ENABLE: irq_en     = i_cfg_data[0];
                    default: ;
                endcase
            end
            // results of older items go first, latency keeps them apart
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
                o_items_out <= o_items_out + 1;
            end
            if (i_in_valid && i_in_ready) begin
                advance_timer(i_in_item);
                o_items_in <= o_items_in + 1;
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// testbench top of the pwm timer: stimulus, handshake pacing and the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    capwm_pkg::t_in_item  in_item = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    capwm_pkg::t_out_item o_out_item;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_idx = capwm_pkg::REG_MAX_COUNT;
    logic [15:0]          cfg_data = '0;

    int acc_in;
    int acc_out;
    int fail_count;

    int burst_left = 0;
    int n_tick = 0;
    int n_duty = 0;
    int n_force = 0;
    int n_nop = 0;
    int n_settings = 1;
    int stalled = 0;
    bit hold_done = 0;

    center_aligned_pwm_timer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    capwm_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_items_in   (acc_in),
        .o_items_out  (acc_out),
        .o_fail_count (fail_count)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic capwm_pkg::t_in_item make_item(input logic [1:0] mode,
                                                      input logic [15:0] d1,
                                                      input logic [15:0] d2,
                                                      input logic [15:0] d3,
                                                      input logic [15:0] d4);
        capwm_pkg::t_in_item it;
        it.mode       = mode;
        it.duty_one   = d1;
        it.duty_two   = d2;
        it.duty_three = d3;
        it.duty_four  = d4;
        return it;
    endfunction

    function automatic logic [15:0] rand_duty();
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'($urandom_range(0, 25600));
            3:       return 16'($urandom);
            4:       return 16'(32'd0 - $urandom_range(1, 32768));
            5:       return 16'($urandom_range(25601, 32767));
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 16'd0;
                    1:       return 16'd25600;
                    2:       return 16'd25601;
                    3:       return 16'hffff;
                    4:       return 16'h7fff;
                    default: return 16'h8000;
                endcase
            end
        endcase
    endfunction

    // sender: bursts of items with random gaps in between
    task automatic push_item(input capwm_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!o_in_ready);
        burst_left--;
        case (it.mode)
            capwm_pkg::MODE_TICK:  n_tick++;
            capwm_pkg::MODE_DUTY:  n_duty++;
            capwm_pkg::MODE_FORCE: n_force++;
            default:               n_nop++;
        endcase
    endtask

    task automatic push_mode(input logic [1:0] mode);
        push_item(make_item(mode, rand_duty(), rand_duty(), rand_duty(), rand_duty()));
    endtask

    task automatic run_random(input int count, input int tick_pct);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)  push_mode(capwm_pkg::MODE_TICK);
            else if (r < 90)   push_mode(capwm_pkg::MODE_DUTY);
            else if (r < 96)   push_mode(capwm_pkg::MODE_FORCE);
            else               push_mode(MODE_NOP);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (acc_in != acc_out);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] period, input logic run,
                                  input logic [3:0] chans, input logic [3:0] inv,
                                  input logic irq);
        drain();
        write_reg(capwm_pkg::REG_MAX_COUNT, period);
        write_reg(capwm_pkg::REG_CNT_ENABLE, {15'd0, run});
        write_reg(capwm_pkg::REG_CH_ENABLE, {12'd0, chans});
        write_reg(capwm_pkg::REG_POL_INVERT, {12'd0, inv});
        write_reg(capwm_pkg::REG_IRQ_ENABLE, {15'd0, irq});
        cfg_we <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // receiver: stall pattern changes after each random span, one long hold-off
    initial begin
        int style;
        int span;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!hold_done && acc_in >= 300 && in_valid) begin
                hold_done = 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 64);
            for (int i = 0; i < span; i++) begin
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= i[0];
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles where nothing moves
    initial begin
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we)
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [15:0] period;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: duty extremes, preload versus active, unused mode
        repeat (3) push_mode(capwm_pkg::MODE_TICK);
        push_item(make_item(capwm_pkg::MODE_DUTY, 16'd0, 16'd25600, 16'h8000, 16'h7fff));
        push_item(make_item(capwm_pkg::MODE_TICK, '0, '0, '0, '0));
        push_item(make_item(capwm_pkg::MODE_DUTY, 16'hffff, 16'd25601, 16'd12800, 16'h0100));
        push_mode(MODE_NOP);
        push_item(make_item(capwm_pkg::MODE_FORCE, '0, '0, '0, '0));
        repeat (4) push_mode(capwm_pkg::MODE_TICK);
        push_item(make_item(capwm_pkg::MODE_DUTY, 16'd256, 16'd6400, 16'd19200, 16'd25599));
        push_mode(capwm_pkg::MODE_TICK);
        push_mode(capwm_pkg::MODE_FORCE);
        push_mode(MODE_NOP);
        repeat (6) push_mode(capwm_pkg::MODE_TICK);

        // shortest period, counter starts past the reload
        apply_settings(16'd2, 1'b1, 4'hf, 4'h0, 1'b1);
        run_random(60, 70);
        // periods below two
        apply_settings(16'd0, 1'b1, 4'ha, 4'h5, 1'b1);
        run_random(40, 65);
        apply_settings(16'd1, 1'b0, 4'hf, 4'hf, 1'b0);
        run_random(40, 65);

        // bring the counter into its falling half, then shrink the period under it
        apply_settings(16'd12, 1'b1, 4'hf, 4'h0, 1'b1);
        push_mode(capwm_pkg::MODE_DUTY);
        push_mode(capwm_pkg::MODE_FORCE);
        repeat (15) push_mode(capwm_pkg::MODE_TICK);
        apply_settings(16'd4, 1'b1, 4'h6, 4'h9, 1'b1);
        run_random(40, 75);

        apply_settings(16'hffff, 1'b1, 4'hf, 4'h3, 1'b1);
        run_random(70, 40);

        repeat (6) begin
            case ($urandom_range(0, 3))
                0, 1:    period = 16'($urandom_range(2, 40));
                2:       period = 16'($urandom_range(41, 700));
                default: period = 16'($urandom_range(0, 3));
            endcase
            apply_settings(period, $urandom_range(0, 7) != 0, 4'($urandom),
                           4'($urandom), 1'($urandom));
            run_random(60, 75);
        end

        drain();
        $display("run covered %0d items: %0d ticks, %0d duty sets, %0d forced, %0d unused",
                 acc_in, n_tick, n_duty, n_force, n_nop);
        $display("over %0d register settings, %0d results checked, %0d mismatches",
                 n_settings, acc_out, fail_count);
        if (fail_count == 0 && acc_in == acc_out)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
sv/capwm_pkg.sv
sv/capwm_duty_scale.sv
sv/center_aligned_pwm_timer_top.sv
tb/capwm_checker.sv
tb/testbench.sv
